>>> hw/rtl/mdp_reachability_value_iteration_macros.svh
// Assertion macros used by the value iteration engine.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef MDP_REACHABILITY_VALUE_ITERATION_MACROS_SVH
`define MDP_REACHABILITY_VALUE_ITERATION_MACROS_SVH

// Same-cycle implication check
`define MDPRVI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define MDPRVI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mdprvi_pkg.sv
// Shared types, constants and helpers of the value iteration block.
// Used by mdprvi_engine and the top level; depends on nothing.
`timescale 1ns / 1ps

package mdprvi_pkg;

  localparam int VALUE_W  = 32;
  localparam int FRAC     = VALUE_W - 1;
  localparam int IDX_W    = 10;
  localparam int CHOICE_W = 13;
  localparam int ITER_W   = 20;
  localparam int CMD_W    = 3;

  localparam logic [VALUE_W-1:0]  ONE       = VALUE_W'(1) << FRAC;
  localparam logic [CHOICE_W-1:0] NO_CHOICE = '1;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_STATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHOICE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRANS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RUN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MIN_MODE = 2'd0;
  localparam logic [1:0] REG_REL_MODE = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;
  localparam logic [1:0] REG_MAX_ITER = 2'd3;

  typedef struct packed {
    logic                min_mode;
    logic                relative_mode;
    logic [VALUE_W-1:0]  threshold;
    logic [ITER_W-1:0]   max_iter;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    logic [IDX_W-1:0]    idx;
  } req_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [CHOICE_W-1:0] choice;
    logic                converged;
    logic [ITER_W-1:0]   iters;
  } resp_t;

  // Engine sequencer states
  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_RD      = 20'h00002,
    ST_INIT_RD = 20'h00004,
    ST_INIT_WR = 20'h00008,
    ST_SA      = 20'h00010,
    ST_SB      = 20'h00020,
    ST_SC      = 20'h00040,
    ST_CA      = 20'h00080,
    ST_CB      = 20'h00100,
    ST_CC      = 20'h00200,
    ST_EA      = 20'h00400,
    ST_EB      = 20'h00800,
    ST_EC      = 20'h01000,
    ST_ED      = 20'h02000,
    ST_CEND    = 20'h04000,
    ST_NOCH    = 20'h08000,
    ST_WR      = 20'h10000,
    ST_TST     = 20'h20000,
    ST_SEND    = 20'h40000,
    ST_SPARE   = 20'h80000
  } eng_state_t;

  // Clamp an external Q1.31 value to one
  function automatic logic [VALUE_W-1:0] load_q(input logic [VALUE_W-1:0] x);
    load_q = (x > ONE) ? ONE : x;
  endfunction

endpackage

>>> hw/rtl/mdprvi_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Leaf module; depends on nothing.
`timescale 1ns / 1ps

module mdprvi_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mdprvi_engine.sv
// Matrix store and value iteration sequencer: loads, runs sweeps, serves reads.
// Depends on mdprvi_pkg, mdprvi_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "mdp_reachability_value_iteration_macros.svh"

module mdprvi_engine #(
  parameter int MAX_STATES  = 1024,
  parameter int MAX_CHOICES = 4096,
  parameter int MAX_ENTRIES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mdprvi_pkg::cfg_t   cfg,
  input  mdprvi_pkg::req_t   req,
  output logic               busy,
  output mdprvi_pkg::resp_t  resp
);

  localparam int VW  = mdprvi_pkg::VALUE_W;
  localparam int SW  = $clog2(MAX_STATES);
  localparam int NSW = $clog2(MAX_STATES + 1);
  localparam int CW  = $clog2(MAX_CHOICES);
  localparam int NCW = $clog2(MAX_CHOICES + 1);
  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int NEW = $clog2(MAX_ENTRIES + 1);
  localparam int TW  = (NSW > mdprvi_pkg::IDX_W) ? NSW : mdprvi_pkg::IDX_W;
  localparam int BW  = CW + 1;

  localparam logic [BW-1:0] BC_NONE = {1'b1, CW'(0)};

  mdprvi_pkg::eng_state_t state_r, state_nxt;

  logic [NSW-1:0] ns_r, ns_nxt, i_r, i_nxt;
  logic [NCW-1:0] nc_r, nc_nxt, j_r, j_nxt, ch_r, ch_nxt;
  logic [NEW-1:0] ne_r, ne_nxt, k_r, k_nxt, eh_r, eh_nxt;
  logic           cur_r, cur_nxt, first_r, first_nxt, pass_all_r, pass_all_nxt;
  logic           conv_r, conv_nxt, rdok_r, rdok_nxt;
  logic [mdprvi_pkg::ITER_W-1:0] iters_r, iters_nxt, last_iters_r, last_iters_nxt;
  logic [VW-1:0]  acc_r, acc_nxt, best_r, best_nxt, oldi_r, oldi_nxt;
  logic [VW-1:0]  nv_r, nv_nxt, diff_r, diff_nxt, p_r, p_nxt;
  logic [BW-1:0]  besti_r, besti_nxt;
  logic [mdprvi_pkg::IDX_W-1:0] t_r, t_nxt;
  logic [2*VW-1:0] prod_r, prod_nxt;

  // Memory ports
  logic          y_we, va_we, vb_we, sfc_we, cfe_we, ent_we, bc_we;
  logic [SW-1:0] y_wa, y_ra, v_wa, v_ra, sfc_wa, sfc_ra, bc_wa, bc_ra;
  logic [CW-1:0] cfe_wa, cfe_ra;
  logic [EW-1:0] ent_wa, ent_ra;
  logic [VW-1:0] y_wd, v_wd, ep_wd;
  logic [NCW-1:0] sfc_wd;
  logic [NEW-1:0] cfe_wd;
  logic [mdprvi_pkg::IDX_W-1:0] et_wd;
  logic [BW-1:0] bc_wd;
  logic [VW-1:0] y_rd, va_rd, vb_rd, ep_rd, old_rd;
  logic [NCW-1:0] sfc_rd;
  logic [NEW-1:0] cfe_rd;
  logic [mdprvi_pkg::IDX_W-1:0] et_rd;
  logic [BW-1:0] bc_rd;

  mdprvi_ram #(.DEPTH(MAX_STATES), .WIDTH(VW)) u_yes (
    .clk, .we(y_we), .waddr(y_wa), .wdata(y_wd), .raddr(y_ra), .rdata(y_rd));
  mdprvi_ram #(.DEPTH(MAX_STATES), .WIDTH(VW)) u_bank_a (
    .clk, .we(va_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(va_rd));
  mdprvi_ram #(.DEPTH(MAX_STATES), .WIDTH(VW)) u_bank_b (
    .clk, .we(vb_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(vb_rd));
  mdprvi_ram #(.DEPTH(MAX_STATES), .WIDTH(NCW)) u_sfc (
    .clk, .we(sfc_we), .waddr(sfc_wa), .wdata(sfc_wd), .raddr(sfc_ra), .rdata(sfc_rd));
  mdprvi_ram #(.DEPTH(MAX_CHOICES), .WIDTH(NEW)) u_cfe (
    .clk, .we(cfe_we), .waddr(cfe_wa), .wdata(cfe_wd), .raddr(cfe_ra), .rdata(cfe_rd));
  mdprvi_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(VW)) u_eprob (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(ep_wd), .raddr(ent_ra), .rdata(ep_rd));
  mdprvi_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(mdprvi_pkg::IDX_W)) u_etgt (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(et_wd), .raddr(ent_ra), .rdata(et_rd));
  mdprvi_ram #(.DEPTH(MAX_STATES), .WIDTH(BW)) u_best (
    .clk, .we(bc_we), .waddr(bc_wa), .wdata(bc_wd), .raddr(bc_ra), .rdata(bc_rd));

  assign old_rd = cur_r ? vb_rd : va_rd;

  // Datapath helpers
  logic [NCW-1:0] ch_c, cl_c;
  logic [NEW-1:0] eh_c, kl_c;
  logic           t_ok, take_c, pick_c, pass_c;
  logic [VW:0]    p_c;
  logic [VW+1:0]  sum_c;
  logic [VW-1:0]  acc_upd, diff_c;
  logic [mdprvi_pkg::ITER_W-1:0] iters_inc;
  logic [mdprvi_pkg::CHOICE_W-1:0] rd_choice;

  always_comb begin
    ch_c    = ((i_r + NSW'(1)) < ns_r) ? sfc_rd : nc_r;
    cl_c    = (j_r > ch_c) ? ch_c : j_r;
    eh_c    = ((j_r + NCW'(1)) < nc_r) ? cfe_rd : ne_r;
    kl_c    = (k_r > eh_c) ? eh_c : k_r;
    t_ok    = TW'(t_r) < TW'(ns_r);
    p_c     = {1'b0, prod_r[2*VW-2:VW-1]};
    sum_c   = {2'b00, acc_r} + {1'b0, p_c};
    acc_upd = (sum_c > (VW+2)'(mdprvi_pkg::ONE)) ? mdprvi_pkg::ONE : sum_c[VW-1:0];
    take_c  = first_r || (cfg.min_mode && (acc_r < best_r)) ||
              (!cfg.min_mode && (acc_r > best_r));
    pick_c  = take_c && (cfg.min_mode || besti_r[CW] || (acc_r > oldi_r));
    diff_c  = (nv_r > oldi_r) ? (nv_r - oldi_r) : (oldi_r - nv_r);
    if (cfg.relative_mode) begin
      pass_c = (diff_r == '0) ||
               ({1'b0, diff_r, {mdprvi_pkg::FRAC{1'b0}}} < prod_r);
    end else begin
      pass_c = diff_r < cfg.threshold;
    end
    iters_inc = iters_r + mdprvi_pkg::ITER_W'(1);
    rd_choice = bc_rd[CW] ? mdprvi_pkg::NO_CHOICE : mdprvi_pkg::CHOICE_W'(bc_rd[CW-1:0]);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ns_nxt = ns_r; nc_nxt = nc_r; ne_nxt = ne_r;
    i_nxt = i_r; j_nxt = j_r; ch_nxt = ch_r; k_nxt = k_r; eh_nxt = eh_r;
    cur_nxt = cur_r; first_nxt = first_r; pass_all_nxt = pass_all_r;
    conv_nxt = conv_r; rdok_nxt = rdok_r;
    iters_nxt = iters_r; last_iters_nxt = last_iters_r;
    acc_nxt = acc_r; best_nxt = best_r; oldi_nxt = oldi_r; nv_nxt = nv_r;
    diff_nxt = diff_r; p_nxt = p_r; besti_nxt = besti_r; t_nxt = t_r;
    prod_nxt = prod_r;

    y_we = 1'b0; va_we = 1'b0; vb_we = 1'b0; sfc_we = 1'b0;
    cfe_we = 1'b0; ent_we = 1'b0; bc_we = 1'b0;
    y_wa = SW'(ns_r); y_ra = SW'(i_r); y_wd = mdprvi_pkg::load_q(req.value);
    v_wa = SW'(ns_r); v_ra = SW'(i_r); v_wd = mdprvi_pkg::load_q(req.value);
    sfc_wa = SW'(ns_r); sfc_ra = SW'(i_r); sfc_wd = nc_r;
    cfe_wa = CW'(nc_r); cfe_ra = CW'(j_r); cfe_wd = ne_r;
    ent_wa = EW'(ne_r); ent_ra = EW'(k_r);
    ep_wd = mdprvi_pkg::load_q(req.value); et_wd = req.idx;
    bc_wa = SW'(ns_r); bc_ra = SW'(i_r); bc_wd = BC_NONE;

    resp.valid     = 1'b0;
    resp.value     = '0;
    resp.choice    = mdprvi_pkg::NO_CHOICE;
    resp.converged = conv_r;
    resp.iters     = last_iters_r;

    unique case (state_r)
      mdprvi_pkg::ST_IDLE: begin
        if (req.valid) begin
          priority case (req.cmd)
            mdprvi_pkg::CMD_STATE: begin
              if (ns_r < NSW'(MAX_STATES)) begin
                y_we = 1'b1; va_we = 1'b1; vb_we = 1'b1;
                sfc_we = 1'b1; bc_we = 1'b1;
                ns_nxt = ns_r + NSW'(1);
              end
            end
            mdprvi_pkg::CMD_CHOICE: begin
              if ((ns_r != '0) && (nc_r < NCW'(MAX_CHOICES))) begin
                cfe_we = 1'b1;
                nc_nxt = nc_r + NCW'(1);
              end
            end
            mdprvi_pkg::CMD_TRANS: begin
              if ((nc_r != '0) && (ne_r < NEW'(MAX_ENTRIES))) begin
                ent_we = 1'b1;
                ne_nxt = ne_r + NEW'(1);
              end
            end
            mdprvi_pkg::CMD_RUN: begin
              i_nxt = '0;
              state_nxt = mdprvi_pkg::ST_INIT_RD;
            end
            mdprvi_pkg::CMD_READ: begin
              v_ra = SW'(req.idx);
              bc_ra = SW'(req.idx);
              rdok_nxt = TW'(req.idx) < TW'(ns_r);
              state_nxt = mdprvi_pkg::ST_RD;
            end
            default: ;
          endcase
        end
      end
      mdprvi_pkg::ST_RD: begin
        resp.valid  = 1'b1;
        resp.value  = rdok_r ? old_rd : '0;
        resp.choice = rdok_r ? rd_choice : mdprvi_pkg::NO_CHOICE;
        state_nxt   = mdprvi_pkg::ST_IDLE;
      end
      // Copy yes values into the current bank and clear best choices
      mdprvi_pkg::ST_INIT_RD: begin
        if (i_r < ns_r) begin
          state_nxt = mdprvi_pkg::ST_INIT_WR;
        end else if (cfg.max_iter == '0) begin
          conv_nxt = 1'b0;
          last_iters_nxt = '0;
          resp.valid = 1'b1;
          resp.converged = 1'b0;
          resp.iters = '0;
          state_nxt = mdprvi_pkg::ST_IDLE;
        end else begin
          iters_nxt = '0;
          i_nxt = '0;
          pass_all_nxt = cfg.threshold != '0;
          state_nxt = mdprvi_pkg::ST_SA;
        end
      end
      mdprvi_pkg::ST_INIT_WR: begin
        v_wa = SW'(i_r); v_wd = y_rd;
        va_we = !cur_r; vb_we = cur_r;
        bc_wa = SW'(i_r); bc_we = 1'b1;
        i_nxt = i_r + NSW'(1);
        state_nxt = mdprvi_pkg::ST_INIT_RD;
      end
      // Per-state head: fetch choice range, old value and best choice
      mdprvi_pkg::ST_SA: begin
        state_nxt = (i_r < ns_r) ? mdprvi_pkg::ST_SB : mdprvi_pkg::ST_SEND;
      end
      mdprvi_pkg::ST_SB: begin
        j_nxt = sfc_rd; oldi_nxt = old_rd; besti_nxt = bc_rd;
        sfc_ra = SW'(i_r + NSW'(1));
        state_nxt = mdprvi_pkg::ST_SC;
      end
      mdprvi_pkg::ST_SC: begin
        ch_nxt = ch_c; j_nxt = cl_c; first_nxt = 1'b1; best_nxt = '0;
        state_nxt = (cl_c < ch_c) ? mdprvi_pkg::ST_CA : mdprvi_pkg::ST_NOCH;
      end
      // Per-choice head: fetch entry range
      mdprvi_pkg::ST_CA: begin
        state_nxt = mdprvi_pkg::ST_CB;
      end
      mdprvi_pkg::ST_CB: begin
        k_nxt = cfe_rd;
        cfe_ra = CW'(j_r + NCW'(1));
        state_nxt = mdprvi_pkg::ST_CC;
      end
      mdprvi_pkg::ST_CC: begin
        eh_nxt = eh_c; k_nxt = kl_c; acc_nxt = '0;
        state_nxt = (kl_c < eh_c) ? mdprvi_pkg::ST_EA : mdprvi_pkg::ST_CEND;
      end
      // Entry loop: probability times old target value, saturating sum
      mdprvi_pkg::ST_EA: begin
        state_nxt = mdprvi_pkg::ST_EB;
      end
      mdprvi_pkg::ST_EB: begin
        p_nxt = ep_rd; t_nxt = et_rd;
        v_ra = SW'(et_rd);
        state_nxt = mdprvi_pkg::ST_EC;
      end
      mdprvi_pkg::ST_EC: begin
        prod_nxt = (2*VW)'(p_r) * (2*VW)'(t_ok ? old_rd : '0);
        state_nxt = mdprvi_pkg::ST_ED;
      end
      mdprvi_pkg::ST_ED: begin
        acc_nxt = acc_upd;
        k_nxt = k_r + NEW'(1);
        state_nxt = ((k_r + NEW'(1)) < eh_r) ? mdprvi_pkg::ST_EA : mdprvi_pkg::ST_CEND;
      end
      // Choice done: keep better sum; index too if unset, min mode or above old
      mdprvi_pkg::ST_CEND: begin
        first_nxt = 1'b0;
        if (take_c) begin
          best_nxt = acc_r;
        end
        if (pick_c) begin
          besti_nxt = {1'b0, CW'(j_r)};
        end
        j_nxt = j_r + NCW'(1);
        if ((j_r + NCW'(1)) < ch_r) begin
          state_nxt = mdprvi_pkg::ST_CA;
        end else begin
          nv_nxt = take_c ? acc_r : best_r;
          state_nxt = mdprvi_pkg::ST_WR;
        end
      end
      mdprvi_pkg::ST_NOCH: begin
        nv_nxt = y_rd;
        state_nxt = mdprvi_pkg::ST_WR;
      end
      // Write the new value, start the convergence test
      mdprvi_pkg::ST_WR: begin
        v_wa = SW'(i_r); v_wd = nv_r;
        va_we = cur_r; vb_we = !cur_r;
        bc_wa = SW'(i_r); bc_wd = besti_r; bc_we = 1'b1;
        diff_nxt = diff_c;
        prod_nxt = (2*VW)'(cfg.threshold) * (2*VW)'(nv_r);
        state_nxt = mdprvi_pkg::ST_TST;
      end
      mdprvi_pkg::ST_TST: begin
        if (!pass_c) begin
          pass_all_nxt = 1'b0;
        end
        i_nxt = i_r + NSW'(1);
        state_nxt = mdprvi_pkg::ST_SA;
      end
      // Sweep done: swap banks, stop or go again
      mdprvi_pkg::ST_SEND: begin
        cur_nxt = !cur_r;
        iters_nxt = iters_inc;
        if (pass_all_r || (iters_inc >= cfg.max_iter)) begin
          conv_nxt = pass_all_r;
          last_iters_nxt = iters_inc;
          resp.valid = 1'b1;
          resp.converged = pass_all_r;
          resp.iters = iters_inc;
          state_nxt = mdprvi_pkg::ST_IDLE;
        end else begin
          i_nxt = '0;
          pass_all_nxt = cfg.threshold != '0;
          state_nxt = mdprvi_pkg::ST_SA;
        end
      end
      default: begin
        state_nxt = mdprvi_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state_r != mdprvi_pkg::ST_IDLE;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdprvi_pkg::ST_IDLE;
      ns_r <= '0; nc_r <= '0; ne_r <= '0;
      cur_r <= 1'b0; conv_r <= 1'b0; last_iters_r <= '0;
    end else begin
      state_r <= state_nxt;
      ns_r <= ns_nxt; nc_r <= nc_nxt; ne_r <= ne_nxt;
      cur_r <= cur_nxt; conv_r <= conv_nxt; last_iters_r <= last_iters_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; ch_r <= ch_nxt; k_r <= k_nxt; eh_r <= eh_nxt;
    first_r <= first_nxt; pass_all_r <= pass_all_nxt; rdok_r <= rdok_nxt;
    iters_r <= iters_nxt; acc_r <= acc_nxt; best_r <= best_nxt;
    oldi_r <= oldi_nxt; nv_r <= nv_nxt; diff_r <= diff_nxt; p_r <= p_nxt;
    besti_r <= besti_nxt; t_r <= t_nxt; prod_r <= prod_nxt;
  end

  `MDPRVI_ASSERT_IMP(a_state_in_range, clk, rst_n, state_r == mdprvi_pkg::ST_SB, i_r < ns_r, "sweep state index beyond loaded states")
  `MDPRVI_ASSERT_IMP(a_choice_in_range, clk, rst_n, state_r == mdprvi_pkg::ST_CA, j_r < ch_r, "choice index beyond state range")
  `MDPRVI_ASSERT_IMP(a_entry_in_range, clk, rst_n, state_r == mdprvi_pkg::ST_EA, k_r < eh_r, "entry index beyond choice range")
  `MDPRVI_ASSERT_NXT(a_sweep_end, clk, rst_n, state_r == mdprvi_pkg::ST_SEND, (state_r == mdprvi_pkg::ST_IDLE) || (state_r == mdprvi_pkg::ST_SA), "bad transfer out of sweep end")

endmodule

>>> hw/rtl/mdp_reachability_value_iteration.sv
// Top level of the min/max reachability value iteration block.
// Depends on mdprvi_pkg and mdprvi_engine (which uses mdprvi_ram).
`timescale 1ns / 1ps

// Load commands (new state, new choice, transition) are accepted back to back
// while no run or read is in progress, also while a result waits on the
// output. A run first copies the yes values into the current value bank and
// clears the best choices, then sweeps over all states, choices and
// transitions through the single read port of each matrix memory; the run
// result appears after at most max_iterations sweeps. No clearing pass is
// needed after reset.
module mdp_reachability_value_iteration #(
  parameter int MAX_STATES  = 1024,
  parameter int MAX_CHOICES = 4096,
  parameter int MAX_ENTRIES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [9:0]  in_state_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic signed [12:0] out_chosen_choice,
  output logic        out_converged,
  output logic [19:0] out_iterations,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mdprvi_pkg::cfg_t  cfg_r, cfg_nxt;
  mdprvi_pkg::req_t  req;
  mdprvi_pkg::resp_t resp;
  logic              busy, needs_out, in_xfer;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_value_r;
  logic [12:0]       out_choice_r;
  logic              out_conv_r;
  logic [19:0]       out_iters_r;

  // Configuration registers
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        mdprvi_pkg::REG_MIN_MODE: cfg_nxt.min_mode = cfg_pwdata[0];
        mdprvi_pkg::REG_REL_MODE: cfg_nxt.relative_mode = cfg_pwdata[0];
        mdprvi_pkg::REG_THRESH:   cfg_nxt.threshold = cfg_pwdata;
        mdprvi_pkg::REG_MAX_ITER: cfg_nxt.max_iter = cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      mdprvi_pkg::REG_MIN_MODE: cfg_prdata = {31'd0, cfg_r.min_mode};
      mdprvi_pkg::REG_REL_MODE: cfg_prdata = {31'd0, cfg_r.relative_mode};
      mdprvi_pkg::REG_THRESH:   cfg_prdata = cfg_r.threshold;
      mdprvi_pkg::REG_MAX_ITER: cfg_prdata = {12'd0, cfg_r.max_iter};
      default:                  cfg_prdata = '0;
    endcase
  end

  // Input transfer: results need a free output slot
  assign needs_out = (in_command == mdprvi_pkg::CMD_RUN) ||
                     (in_command == mdprvi_pkg::CMD_READ);
  assign in_stall  = busy || (out_valid_r && needs_out);
  assign in_xfer   = in_valid && !in_stall;

  assign req.valid = in_xfer;
  assign req.cmd   = in_command;
  assign req.value = in_value;
  assign req.idx   = in_state_index;

  mdprvi_engine #(
    .MAX_STATES (MAX_STATES),
    .MAX_CHOICES(MAX_CHOICES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_engine (
    .clk,
    .rst_n,
    .cfg (cfg_r),
    .req,
    .busy,
    .resp
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (resp.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_mode      <= 1'b0;
      cfg_r.relative_mode <= 1'b0;
      cfg_r.threshold     <= 32'd2147;
      cfg_r.max_iter      <= 20'd10000;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.valid) begin
      out_value_r  <= resp.value;
      out_choice_r <= resp.choice;
      out_conv_r   <= resp.converged;
      out_iters_r  <= resp.iters;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_chosen_choice = out_choice_r;
  assign out_converged     = out_conv_r;
  assign out_iterations    = out_iters_r;

endmodule

>>> tb/sv/tb_mdp_reachability_value_iteration.sv
// Self-checking testbench of mdp_reachability_value_iteration: loads sparse matrices,
// runs value iteration under several settings and checks every run and read result.
// Depends on mdprvi_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_mdp_reachability_value_iteration;

  localparam int N_STATES  = 1024;
  localparam int N_CHOICES = 4096;
  localparam int N_ENTRIES = 16384;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [9:0]  idx;
  } item_t;

  typedef struct {
    logic [31:0] value;
    logic [12:0] choice;
    logic        converged;
    logic [19:0] iters;
  } outcome_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  in_command;
  logic [31:0] in_value;
  logic [9:0]  in_state_index;
  logic        out_valid, out_stall;
  logic [31:0] out_result_value;
  logic signed [12:0] out_chosen_choice;
  logic        out_converged;
  logic [19:0] out_iterations;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  mdp_reachability_value_iteration uut (.*);

  item_t    pending_q[$];
  outcome_t outcome_q[$];
  item_t    cur_item;
  int       fails = 0;
  int       cycles = 0;
  int       src_idle_pct = 0, dst_idle_pct = 0;
  int       hold_cnt = 0;
  bit       hold_req = 0;
  int       gen_states = 0, gen_items = 0;

  // Shadow of the block: registers, matrix and value banks
  logic        sh_min, sh_rel;
  logic [31:0] sh_thr;
  logic [19:0] sh_max_iter;
  logic [31:0] yes_val[N_STATES];
  logic [31:0] val_bank[2][N_STATES];
  int unsigned first_choice[N_STATES+1];
  int unsigned first_entry[N_CHOICES+1];
  logic [31:0] ent_prob[N_ENTRIES];
  logic [9:0]  ent_tgt[N_ENTRIES];
  int          best_ch[N_STATES];
  int unsigned n_states, n_choices, n_entries;
  int          cur_bank;
  logic        last_conv;
  logic [19:0] last_iters;

  function automatic logic [31:0] clamp_one(logic [31:0] x);
    return (x > Q_ONE) ? Q_ONE : x;
  endfunction

  // One Jacobi sweep over all loaded states; returns 1 if every state converged and the threshold is nonzero
  function automatic bit value_sweep();
    int unsigned cl, ch, el, eh, t;
    logic [63:0] best, nv, acc, p, v, diff, old_v;
    bit first, pass, pass_all;
    pass_all = (sh_thr != 0);
    for (int unsigned i = 0; i < n_states; i++) begin
      cl = first_choice[i];
      ch = first_choice[i+1];
      if (ch > n_choices) ch = n_choices;
      if (cl > ch) cl = ch;
      best = 0;
      first = 1;
      old_v = val_bank[cur_bank][i];
      for (int unsigned j = cl; j < ch; j++) begin
        el = first_entry[j];
        eh = first_entry[j+1];
        if (eh > n_entries) eh = n_entries;
        if (el > eh) el = eh;
        acc = 0;
        for (int unsigned k = el; k < eh; k++) begin
          t = ent_tgt[k];
          v = (t < n_states) ? 64'(val_bank[cur_bank][t]) : 64'd0;
          p = (64'(ent_prob[k]) * v) >> 31;
          acc = (acc > 64'(Q_ONE) - p) ? 64'(Q_ONE) : acc + p;
        end
        if (first || (sh_min && acc < best) || (!sh_min && acc > best)) begin
          best = acc;
          // max mode keeps the old choice unless none is set yet or the sum is strictly above the last value
          if (!sh_min) begin
            if (best_ch[i] == -1 || best > old_v) best_ch[i] = j;
          end else begin
            best_ch[i] = j;
          end
        end
        first = 0;
      end
      nv = (ch > cl) ? best : 64'(yes_val[i]);
      val_bank[cur_bank^1][i] = nv[31:0];
      diff = (nv > old_v) ? nv - old_v : old_v - nv;
      if (!sh_rel) pass = diff < 64'(sh_thr);
      else if (diff == 0) pass = 1;
      else pass = (diff * 64'(Q_ONE)) < (64'(sh_thr) * nv);
      if (!pass) pass_all = 0;
    end
    cur_bank ^= 1;
    return pass_all;
  endfunction

  // Apply one accepted item to the shadow and queue any result it causes
  task automatic predict(item_t it);
    outcome_t r;
    int unsigned s;
    bit done;
    case (it.cmd)
      mdprvi_pkg::CMD_STATE: begin
        s = n_states;
        if (s < N_STATES) begin
          yes_val[s] = clamp_one(it.value);
          val_bank[0][s] = yes_val[s];
          val_bank[1][s] = yes_val[s];
          best_ch[s] = -1;
          first_choice[s] = n_choices;
          first_choice[s+1] = n_choices;
          n_states = s + 1;
        end
      end
      mdprvi_pkg::CMD_CHOICE: begin
        if (n_states > 0 && n_choices < N_CHOICES) begin
          first_entry[n_choices] = n_entries;
          first_entry[n_choices+1] = n_entries;
          n_choices++;
          first_choice[n_states] = n_choices;
        end
      end
      mdprvi_pkg::CMD_TRANS: begin
        if (n_choices > 0 && n_entries < N_ENTRIES) begin
          ent_prob[n_entries] = clamp_one(it.value);
          ent_tgt[n_entries] = it.idx;
          n_entries++;
          first_entry[n_choices] = n_entries;
        end
      end
      mdprvi_pkg::CMD_RUN: begin
        for (int unsigned i = 0; i < n_states; i++) begin
          val_bank[cur_bank][i] = yes_val[i];
          best_ch[i] = -1;
        end
        done = 0;
        last_iters = 0;
        while (!done && last_iters < sh_max_iter) begin
          last_iters++;
          done = value_sweep();
        end
        last_conv = done;
        r.value = 0;
        r.choice = mdprvi_pkg::NO_CHOICE;
        r.converged = last_conv;
        r.iters = last_iters;
        outcome_q.push_back(r);
      end
      mdprvi_pkg::CMD_READ: begin
        if (it.idx < n_states) begin
          r.value = val_bank[cur_bank][it.idx];
          r.choice = best_ch[it.idx][12:0];
        end else begin
          r.value = 0;
          r.choice = mdprvi_pkg::NO_CHOICE;
        end
        r.converged = last_conv;
        r.iters = last_iters;
        outcome_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mdp_reachability_value_iteration regression: fail");
      $finish;
    end
  end

  // Input driver: predicts each transfer, then offers the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) predict(cur_item);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = pending_q.pop_front();
          in_valid <= 1;
          in_command <= cur_item.cmd;
          in_value <= cur_item.value;
          in_state_index <= cur_item.idx;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = outcome_q.pop_front();
          if (out_result_value !== e.value) begin
            $error("result_value expected %0h got %0h", e.value, out_result_value);
            fails++;
          end
          if (out_chosen_choice !== e.choice) begin
            $error("chosen_choice expected %0h got %0h", e.choice, out_chosen_choice);
            fails++;
          end
          if (out_converged !== e.converged) begin
            $error("converged expected %0h got %0h", e.converged, out_converged);
            fails++;
          end
          if (out_iterations !== e.iters) begin
            $error("iterations expected %0h got %0h", e.iters, out_iterations);
            fails++;
          end
        end
      end
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  task automatic push(logic [2:0] cmd, logic [31:0] value, logic [9:0] idx);
    item_t it;
    it.cmd = cmd;
    it.value = value;
    it.idx = idx;
    pending_q.push_back(it);
    gen_items++;
    if (cmd == mdprvi_pkg::CMD_STATE) gen_states++;
  endtask

  // Wait until every item is taken and every result has come out
  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] r, logic [31:0] d);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (r)
      mdprvi_pkg::REG_MIN_MODE: sh_min = d[0];
      mdprvi_pkg::REG_REL_MODE: sh_rel = d[0];
      mdprvi_pkg::REG_THRESH:   sh_thr = d;
      mdprvi_pkg::REG_MAX_ITER: sh_max_iter = d[19:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(4))
      0: return $urandom();
      1: return Q_ONE;
      2: return 0;
      default: return $urandom_range(Q_ONE);
    endcase
  endfunction

  // One well-formed block of states, choices and transitions
  task automatic load_batch();
    int n_st, n_ch, n_tr;
    logic [9:0] tgt;
    n_st = $urandom_range(1, 3);
    for (int a = 0; a < n_st; a++) begin
      push(mdprvi_pkg::CMD_STATE, rand_q(), 10'($urandom()));
      n_ch = $urandom_range(0, 2);
      for (int b = 0; b < n_ch; b++) begin
        push(mdprvi_pkg::CMD_CHOICE, $urandom(), 10'($urandom()));
        n_tr = $urandom_range(1, 2);
        for (int c = 0; c < n_tr; c++) begin
          tgt = ($urandom_range(9) == 0) ? 10'($urandom()) : 10'($urandom_range(gen_states - 1));
          push(mdprvi_pkg::CMD_TRANS, rand_q(), tgt);
        end
      end
    end
  endtask

  initial begin
    int n_rd, ph;
    sh_min = 0; sh_rel = 0; sh_thr = 2147; sh_max_iter = 10000;
    n_states = 0; n_choices = 0; n_entries = 0; cur_bank = 0;
    last_conv = 0; last_iters = 0;
    for (int i = 0; i < N_STATES; i++) best_ch[i] = -1;
    rst_n = 0;
    in_command = 0; in_value = 0; in_state_index = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Empty matrix, orphan items, out-of-range reads, huge iteration limit
    cfg_write(mdprvi_pkg::REG_MIN_MODE, 1);
    cfg_write(mdprvi_pkg::REG_REL_MODE, 1);
    cfg_write(mdprvi_pkg::REG_THRESH, Q_ONE);
    cfg_write(mdprvi_pkg::REG_MAX_ITER, 32'h000F_FFFF);
    push(mdprvi_pkg::CMD_CHOICE, 0, 0);
    push(mdprvi_pkg::CMD_TRANS, Q_ONE, 0);
    push(mdprvi_pkg::CMD_READ, 0, 0);
    push(mdprvi_pkg::CMD_RUN, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 10'h3FF);
    drain();

    // Small matrix with saturated values, bad target and unused commands
    cfg_write(mdprvi_pkg::REG_MIN_MODE, 0);
    cfg_write(mdprvi_pkg::REG_REL_MODE, 0);
    cfg_write(mdprvi_pkg::REG_THRESH, 32'hFFFF_FFFF);
    cfg_write(mdprvi_pkg::REG_MAX_ITER, 0);
    push(mdprvi_pkg::CMD_STATE, 32'hFFFF_FFFF, 0);
    push(mdprvi_pkg::CMD_CHOICE, 0, 0);
    push(mdprvi_pkg::CMD_TRANS, 32'hFFFF_FFFF, 10'd2);
    push(mdprvi_pkg::CMD_TRANS, 32'h4000_0000, 10'd1);
    push(mdprvi_pkg::CMD_CHOICE, 0, 0);
    push(mdprvi_pkg::CMD_TRANS, 0, 10'h3FF);
    push(mdprvi_pkg::CMD_TRANS, 32'h5555_5555, 10'd0);
    push(mdprvi_pkg::CMD_STATE, 0, 0);
    push(mdprvi_pkg::CMD_STATE, Q_ONE, 0);
    push(mdprvi_pkg::CMD_CHOICE, 0, 0);
    push(mdprvi_pkg::CMD_TRANS, 32'h7FFF_FFFF, 10'd0);
    push(3'd5, 32'hFFFF_FFFF, 10'h3FF);
    push(3'd6, 0, 0);
    push(3'd7, 32'hAAAA_AAAA, 10'h155);
    push(mdprvi_pkg::CMD_RUN, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 0);
    drain();
    cfg_write(mdprvi_pkg::REG_THRESH, 0);
    cfg_write(mdprvi_pkg::REG_MAX_ITER, 4);
    push(mdprvi_pkg::CMD_RUN, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 2);
    drain();
    cfg_write(mdprvi_pkg::REG_MIN_MODE, 1);
    cfg_write(mdprvi_pkg::REG_REL_MODE, 1);
    cfg_write(mdprvi_pkg::REG_THRESH, 32'h4000_0000);
    cfg_write(mdprvi_pkg::REG_MAX_ITER, 6);
    push(mdprvi_pkg::CMD_RUN, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 1);
    push(mdprvi_pkg::CMD_READ, 0, 3);
    drain();

    // Random phases: reconfigure, load, run, read
    ph = 0;
    while (gen_items < 150) begin
      if (gen_items < 60) begin
        src_idle_pct = 7; dst_idle_pct = 51;
      end else if (gen_items < 105) begin
        src_idle_pct = 51; dst_idle_pct = 7;
      end else begin
        src_idle_pct = 0; dst_idle_pct = 0;
      end
      drain();
      cfg_write(mdprvi_pkg::REG_MIN_MODE, $urandom());
      cfg_write(mdprvi_pkg::REG_REL_MODE, $urandom());
      case ($urandom_range(3))
        0: cfg_write(mdprvi_pkg::REG_THRESH, 0);
        1: cfg_write(mdprvi_pkg::REG_THRESH, Q_ONE);
        2: cfg_write(mdprvi_pkg::REG_THRESH, $urandom_range(32'h0010_0000));
        default: cfg_write(mdprvi_pkg::REG_THRESH, $urandom());
      endcase
      cfg_write(mdprvi_pkg::REG_MAX_ITER, $urandom_range(1, 6));
      // long receiver hold-off while loads and reads keep coming
      if (ph == 2) hold_req = 1;
      if (gen_states < 50) begin
        if ($urandom_range(4) != 0) load_batch();
        else for (int n = $urandom_range(1, 3); n > 0; n--)
          push(3'($urandom_range(7)), $urandom(), 10'($urandom()));
      end
      push(mdprvi_pkg::CMD_RUN, $urandom(), 10'($urandom()));
      n_rd = $urandom_range(2, 6);
      for (int n = 0; n < n_rd; n++) begin
        if ($urandom_range(6) != 0)
          push(mdprvi_pkg::CMD_READ, $urandom(), 10'($urandom_range(gen_states - 1)));
        else push(mdprvi_pkg::CMD_READ, $urandom(), 10'($urandom()));
      end
      ph++;
    end

    // Fill the state store past its end, then one short run
    drain();
    src_idle_pct = 0; dst_idle_pct = 0;
    cfg_write(mdprvi_pkg::REG_MIN_MODE, 0);
    cfg_write(mdprvi_pkg::REG_MAX_ITER, 1);
    while (gen_states < N_STATES + 2) push(mdprvi_pkg::CMD_STATE, $urandom(), 10'($urandom()));
    push(mdprvi_pkg::CMD_RUN, 0, 0);
    push(mdprvi_pkg::CMD_READ, 0, 10'h3FF);
    for (int n = 0; n < 20; n++) push(mdprvi_pkg::CMD_READ, $urandom(), 10'($urandom()));

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("mdp_reachability_value_iteration regression: pass");
    else $display("mdp_reachability_value_iteration regression: fail");
    $finish;
  end

endmodule

>>> mdp_reachability_value_iteration.f
+incdir+hw/rtl
hw/rtl/mdprvi_pkg.sv
hw/rtl/mdprvi_ram.sv
hw/rtl/mdprvi_engine.sv
hw/rtl/mdp_reachability_value_iteration.sv
tb/sv/tb_mdp_reachability_value_iteration.sv
